FILE: rtl/core/periodic_callback_timer_table_defines.svh
// Assertion macros used by the timer table RTL.
`ifndef PERIODIC_CALLBACK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_CALLBACK_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pctt_pkg.sv
// Package: sizes, command codes and record types of the timer table.
`timescale 1ns / 1ps

package pctt_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = 8;
  localparam int PER_W  = 16;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd3;

  localparam logic [SLOT_W-1:0] NO_HANDLE = 8'd255;

  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] ticks;
  } slot_ent_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              table_full;
    logic              fired;
    logic              last;
  } result_t;

endpackage

FILE: rtl/core/pctt_ifs.sv
// Interfaces: command channel and result channel of the timer table.
`timescale 1ns / 1ps

interface pctt_in_if import pctt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot_id;
  logic [PER_W-1:0]  period;

  modport source (output valid, output command, output slot_id, output period,
                  input ready);
  modport sink (input valid, input command, input slot_id, input period,
                output ready);
endinterface

interface pctt_out_if import pctt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  logic              table_full;
  logic              fired;
  logic              last;

  modport source (output valid, output slot_out, output table_full, output fired,
                  output last, input ready);
  modport sink (input valid, input slot_out, input table_full, input fired,
                input last, output ready);
endinterface

FILE: rtl/core/pctt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module pctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/periodic_callback_timer_table.sv
// Top level: periodic timer slot table with allocate, remove, tick and scan.
//
// Usage: commands enter on in_ch (valid/ready, one transfer per command) and
// results leave on out_ch (valid/ready). Allocate, remove and scan always give
// at least one result; the final result of a command carries last. Tick gives
// none. The block works on one command at a time: in_ch.ready is high only
// while no command is in progress.
// Remove and an allocate with an assigned handle pass their result through the
// response register into the result register. A free-slot allocate walks the
// active bits one slot a cycle, from 1 up to the first free slot, and gives the
// full-table answer if none is free. Tick and scan stream every slot through
// the period/tick RAM (one read and one write-back per cycle while a scan is not
// stalled, registered read); a scan gives its final result after the walk, once
// the last read has been written back.
// Reset clears the active bits; the RAM needs no clearing pass, since an entry
// is written on allocate before any read that matters.
// A stalled receiver: the result register holds its transfer; a scan that finds
// another due slot while a result is still waiting freezes its walk until the
// register frees up, so no result is lost.
`timescale 1ns / 1ps
`include "periodic_callback_timer_table_defines.svh"

module periodic_callback_timer_table import pctt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  pctt_in_if.sink       in_ch,
  pctt_out_if.source    out_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_RESP  = 2'd2;
  localparam logic [1:0] S_WALK  = 2'd3;

  // Control registers
  logic [1:0]       state_r, state_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic             dv_r, dv_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] pend_slot_r, pend_slot_nxt;
  result_t          resp_r, resp_nxt;
  result_t          out_r, out_nxt;

  // RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_ent_t        ram_wdata;
  logic             ram_re;
  slot_ent_t        ram_rdata;

  logic             in_xfer;
  logic             out_free;
  logic             out_load;
  logic             walk_more;
  logic             is_scan;
  logic             cur_active;
  logic             due;
  logic             stall;
  logic             alloc_hit;
  logic [IDX_W-1:0] alloc_idx;

  pctt_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign walk_more  = (idx_r < CNT_W'(SLOTS));
  assign is_scan    = (cmd_r == CMD_SCAN);
  assign cur_active = active_r[rd_idx_r];
  assign due        = cur_active && (ram_rdata.ticks >= ram_rdata.period);
  // Freeze the walk when a due slot must push the pending result out but
  // the result register is still occupied.
  assign stall      = dv_r && is_scan && due && pend_valid_r && !out_free;
  assign ram_re     = (state_r == S_WALK) && walk_more && !stall;
  assign alloc_idx  = idx_r[IDX_W-1:0];
  assign alloc_hit  = (state_r == S_ALLOC) && walk_more && !active_r[alloc_idx];

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    dv_nxt         = dv_r;
    pend_valid_nxt = pend_valid_r;
    cmd_nxt        = cmd_r;
    per_nxt        = per_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    pend_slot_nxt  = pend_slot_r;
    resp_nxt       = resp_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_idx_r;
    ram_wdata      = '0;
    out_load       = 1'b0;
    out_nxt        = out_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt = in_ch.command;
          per_nxt = in_ch.period;
          case (in_ch.command)
            CMD_ALLOC: begin
              if (in_ch.slot_id == '0 || in_ch.slot_id == NO_HANDLE) begin
                idx_nxt   = CNT_W'(1);
                state_nxt = S_ALLOC;
              end else begin
                resp_nxt  = '{slot_out: in_ch.slot_id, table_full: 1'b0,
                              fired: 1'b0, last: 1'b1};
                state_nxt = S_RESP;
              end
            end
            CMD_REMOVE: begin
              // Drop the active bit; the period is rewritten when the slot is next allocated.
              if (in_ch.slot_id != '0 && in_ch.slot_id < SLOT_W'(SLOTS)) begin
                active_nxt[in_ch.slot_id[IDX_W-1:0]] = 1'b0;
                resp_nxt = '{slot_out: '0, table_full: 1'b0, fired: 1'b0, last: 1'b1};
              end else begin
                resp_nxt = '{slot_out: in_ch.slot_id, table_full: 1'b0,
                             fired: 1'b0, last: 1'b1};
              end
              state_nxt = S_RESP;
            end
            default: begin
              idx_nxt        = '0;
              dv_nxt         = 1'b0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_WALK;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (!walk_more) begin
          resp_nxt  = '{slot_out: NO_HANDLE, table_full: 1'b1, fired: 1'b0, last: 1'b1};
          state_nxt = S_RESP;
        end else if (alloc_hit) begin
          active_nxt[alloc_idx] = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = alloc_idx;
          ram_wdata = '{period: per_r, ticks: '0};
          resp_nxt  = '{slot_out: SLOT_W'(alloc_idx), table_full: 1'b0,
                        fired: 1'b0, last: 1'b1};
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = resp_r;
          state_nxt = S_IDLE;
        end
      end

      S_WALK: begin
        // Issue the next read while the previous slot is written back.
        if (ram_re) begin
          idx_nxt    = idx_r + CNT_W'(1);
          rd_idx_nxt = idx_r[IDX_W-1:0];
        end
        if (!stall) begin
          dv_nxt = ram_re;
        end
        if (dv_r && !stall) begin
          if (is_scan) begin
            if (due) begin
              ram_we    = 1'b1;
              ram_wdata = '{period: ram_rdata.period, ticks: '0};
              if (pend_valid_r) begin
                out_load = 1'b1;
                out_nxt  = '{slot_out: SLOT_W'(pend_slot_r), table_full: 1'b0,
                             fired: 1'b1, last: 1'b0};
              end
              pend_valid_nxt = 1'b1;
              pend_slot_nxt  = rd_idx_r;
            end
          end else if (cur_active) begin
            // Inactive counts are never read before a reallocate clears them.
            ram_we    = 1'b1;
            ram_wdata = '{period: ram_rdata.period, ticks: ram_rdata.ticks + PER_W'(1)};
          end
        end
        if (!walk_more && !dv_r) begin
          if (is_scan) begin
            if (pend_valid_r) begin
              resp_nxt = '{slot_out: SLOT_W'(pend_slot_r), table_full: 1'b0,
                           fired: 1'b1, last: 1'b1};
            end else begin
              resp_nxt = '{slot_out: '0, table_full: 1'b0, fired: 1'b0, last: 1'b1};
            end
            pend_valid_nxt = 1'b0;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      dv_r         <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      dv_r         <= dv_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    per_r       <= per_nxt;
    idx_r       <= idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    resp_r      <= resp_nxt;
    out_r       <= out_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_out   = out_r.slot_out;
  assign out_ch.table_full = out_r.table_full;
  assign out_ch.fired      = out_r.fired;
  assign out_ch.last       = out_r.last;

  `PCTT_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_r || out_ch.ready,
    "result register overwritten before its transfer")
  `PCTT_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != idx_r[IDX_W-1:0],
    "slot RAM read and written at the same entry")
  `PCTT_ASSERT_NOW(a_pend_in_walk, pend_valid_r, state_r == S_WALK && is_scan,
    "pending fire result outside a scan walk")
  `PCTT_ASSERT_NEXT(a_alloc_claims, alloc_hit,
    state_r == S_RESP && active_r[$past(alloc_idx)] && !resp_r.table_full,
    "allocate did not claim its slot")

endmodule

FILE: tb/sv/periodic_callback_timer_table_tb.sv
// Self-checking testbench for the periodic timer slot table.
`timescale 1ns / 1ps

module periodic_callback_timer_table_tb import pctt_pkg::*;;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_ITEMS  = 60;
  // One tick or scan walks every slot. Allow a margin.
  localparam int SETTLE_CYCLES = 4 * SLOTS;
  // Longest receiver hold-off, in cycles.
  localparam int LONG_HOLD = 400;
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  // Mirror of the slot table plus the queue of results still owed by the block.
  class timer_slot_predictor;
    bit               active [SLOTS];
    logic [PER_W-1:0] period [SLOTS];
    logic [PER_W-1:0] ticks  [SLOTS];
    result_t          owed[$];
    int unsigned      mismatches;
    int unsigned      seen;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        active[s] = 1'b0;
        period[s] = '0;
        ticks[s]  = '0;
      end
      mismatches = 0;
      seen = 0;
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Apply one accepted command to the mirror and queue the results it owes.
    function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] id,
                               logic [PER_W-1:0] per);
      int s;
      int fired_count;
      result_t r;
      r.slot_out   = id;
      r.table_full = 1'b0;
      r.fired      = 1'b0;
      r.last       = 1'b1;
      case (cmd)
        CMD_ALLOC: begin
          if (id == '0 || id == NO_HANDLE) begin
            s = 1;
            while (s < SLOTS && active[s]) s++;
            if (s < SLOTS) begin
              active[s]  = 1'b1;
              period[s]  = per;
              ticks[s]   = '0;
              r.slot_out = s[SLOT_W-1:0];
            end else begin
              r.slot_out   = NO_HANDLE;
              r.table_full = 1'b1;
            end
          end
          owed.push_back(r);
        end
        CMD_REMOVE: begin
          if (id > 0 && id < SLOTS) begin
            active[id] = 1'b0;
            period[id] = '0;
            r.slot_out = '0;
          end
          owed.push_back(r);
        end
        CMD_TICK: begin
          for (s = 0; s < SLOTS; s++) ticks[s] = ticks[s] + 1'b1;
        end
        CMD_SCAN: begin
          fired_count = 0;
          for (s = 0; s < SLOTS; s++) begin
            if (active[s] && ticks[s] >= period[s]) begin
              ticks[s]     = '0;
              r.slot_out   = s[SLOT_W-1:0];
              r.fired      = 1'b1;
              r.last       = 1'b0;
              owed.push_back(r);
              fired_count++;
            end
          end
          if (fired_count == 0) begin
            r.slot_out = '0;
            owed.push_back(r);
          end else begin
            owed[owed.size()-1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest owed result.
    function void check_result(result_t got);
      result_t want;
      seen++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result %0d: none owed, got slot %0d full %b fired %b last %b",
                                  seen, got.slot_out, got.table_full, got.fired, got.last));
        return;
      end
      want = owed.pop_front();
      if (got.slot_out !== want.slot_out || got.table_full !== want.table_full ||
          got.fired !== want.fired || got.last !== want.last)
        report_mismatch({
          $sformatf("result %0d: expected slot %0d full %b fired %b last %b",
                    seen, want.slot_out, want.table_full, want.fired, want.last),
          $sformatf(", got slot %0d full %b fired %b last %b",
                    got.slot_out, got.table_full, got.fired, got.last)});
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pctt_in_if  in_ch ();
  pctt_out_if out_ch ();

  periodic_callback_timer_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timer_slot_predictor predictor = new();

  // Handshake flags between the sender and the receiver processes.
  bit hold_request = 1'b0;
  bit hold_taken   = 1'b0;
  bit quiet        = 1'b0;

  int unsigned idle_cycles = 0;
  result_t     sampled;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Raise valid with a command and hold it until the block takes the transfer.
  // Valid stays high on return; the caller drops it only when it idles.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] id,
                              logic [PER_W-1:0] per);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.slot_id <= id;
    in_ch.period  <= per;
    do @(posedge clk); while (!in_ch.ready);
    predictor.note_command(cmd, id, per);
  endtask

  // Drop valid and wait until every owed result has arrived, then let any
  // tick still walking the table finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (predictor.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Occasionally (one call in four) drop valid and idle the sender.
  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Draw one command. Most handles are well formed so the table fills, fires and
  // frees slots; the rest are arbitrary handles that hit the out-of-range paths.
  task automatic send_random();
    int pick;
    int shape;
    logic [SLOT_W-1:0] id;
    logic [PER_W-1:0]  per;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    id    = SLOT_W'($urandom_range(0, 255));
    // Keep most periods short so slots come due within a few ticks.
    if (shape < 7)       per = PER_W'($urandom_range(0, 6));
    else if (shape == 7) per = PER_W'($urandom_range(0, 65535));
    else if (shape == 8) per = '1;
    else                 per = PER_W'($urandom_range(7, 40));
    if (pick < 25) begin
      if ($urandom_range(0, 4) != 0) id = $urandom_range(0, 1) ? 8'd0 : NO_HANDLE;
      send_command(CMD_ALLOC, id, per);
    end else if (pick < 45) begin
      if ($urandom_range(0, 4) != 0) id = SLOT_W'($urandom_range(1, SLOTS - 1));
      send_command(CMD_REMOVE, id, per);
    end else if (pick < 75) begin
      send_command(CMD_TICK, id, per);
    end else begin
      send_command(CMD_SCAN, id, per);
    end
  endtask

  // Sender: directed commands, a full drain, then the random stream.
  initial begin
    int k;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_TICK;
    in_ch.slot_id <= '0;
    in_ch.period  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scan an empty table: one idle result.
    send_command(CMD_SCAN, 8'd0, 16'h0000);
    // Remove with handle zero, just past the table, and the unassigned handle.
    send_command(CMD_REMOVE, 8'd0, 16'hffff);
    send_command(CMD_REMOVE, SLOT_W'(SLOTS), 16'h0000);
    send_command(CMD_REMOVE, NO_HANDLE, 16'h0000);
    // Remove a slot in range that was never allocated.
    send_command(CMD_REMOVE, SLOT_W'(SLOTS - 1), 16'h0000);
    // Allocate with a handle already assigned: echoed back, table untouched.
    send_command(CMD_ALLOC, 8'd7, 16'h1234);
    // Allocate across the period extremes and alternating bit patterns.
    send_command(CMD_ALLOC, NO_HANDLE, 16'h0000);
    send_command(CMD_ALLOC, 8'd0, 16'hffff);
    send_command(CMD_ALLOC, 8'd0, 16'h0001);
    send_command(CMD_ALLOC, NO_HANDLE, 16'h5555);
    send_command(CMD_ALLOC, 8'd0, 16'haaaa);
    // A zero period fires on every scan; period one fires after one tick.
    send_command(CMD_TICK, 8'haa, 16'h5555);
    send_command(CMD_SCAN, 8'h55, 16'haaaa);
    // Fill the table, then ask once more: table full.
    for (k = 0; k <= SLOTS - 6; k++) send_command(CMD_ALLOC, 8'd0, 16'h0000);
    send_command(CMD_TICK, 8'd0, 16'h0000);
    send_command(CMD_SCAN, 8'd0, 16'h0000);
    // Free two slots; the next allocate takes the lower one.
    send_command(CMD_REMOVE, SLOT_W'(SLOTS - 1), 16'h0000);
    send_command(CMD_REMOVE, 8'd2, 16'h0000);
    send_command(CMD_ALLOC, 8'd0, 16'h0003);
    drain();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // Hold off the receiver for a long stretch while commands keep coming.
      if (k == 150) hold_request = 1'b1;
      // Pause the sender until every owed result has arrived.
      if (k == 300) drain();
      // Run the tail at full rate on both sides.
      if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_random();
      if (!quiet) sender_gap();
    end
    in_ch.valid <= 1'b0;

    while (predictor.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predictor.mismatches == 0) begin
      $display("periodic_callback_timer_table_tb: clean");
    end else begin
      $display("periodic_callback_timer_table_tb: errors");
    end
    $finish;
  end

  // Receiver: check each result transfer, then pick next cycle's ready.
  int rx_gap  = 0;
  int rx_calm = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sampled.slot_out   = out_ch.slot_out;
      sampled.table_full = out_ch.table_full;
      sampled.fired      = out_ch.fired;
      sampled.last       = out_ch.last;
      predictor.check_result(sampled);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      rx_hold = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      out_ch.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0:       rx_calm = $urandom_range(30, 100);
        1, 2, 3: rx_gap  = $urandom_range(1, 14);
        default: ;
      endcase
      out_ch.ready <= (rx_gap == 0);
      if (rx_gap > 0) rx_gap--;
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("periodic_callback_timer_table_tb: errors");
        $finish;
      end
    end
  end

endmodule

FILE: periodic_callback_timer_table.f
+incdir+rtl/core
rtl/core/pctt_pkg.sv
rtl/core/pctt_ifs.sv
rtl/core/pctt_ram.sv
rtl/core/periodic_callback_timer_table.sv
tb/sv/periodic_callback_timer_table_tb.sv
